>>> hw/rtl/atilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atilt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CW           = 28;  // cordic datapath width
  localparam int ZW           = 25;  // angle accumulator, deg * 65536
  localparam int VW           = 25;  // operand width, counts * 256
  localparam int AW           = 16;  // output angle width
  localparam int GW           = 30;  // gain constant width
  localparam int MAG_LAT      = CORDIC_STEPS + 1;
  localparam int ATAN_LAT     = CORDIC_STEPS + 1;
  localparam int PIPE_DEPTH   = MAG_LAT + ATAN_LAT + 2;

  localparam logic [GW-1:0] INV_GAIN = 30'd652032874;
  localparam logic signed [AW-1:0] QUARTER_TURN = 16'sd23040;

  typedef logic signed [ZW-1:0] ang_tab_t [TAB_LEN];
  localparam ang_tab_t ANGLE_TAB = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379, 25'sd117304,
    25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
    25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29,
    25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0
  };

  typedef struct packed {
    logic signed [VW-1:0] oth;
    logic                 neg;
  } side_t;

  typedef struct packed {
    logic dz;
    logic nz;
    logic npos;
    logic neg;
  } spc_t;

endpackage
`default_nettype wire

>>> hw/rtl/accel_tilt_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// Tilt angles from a raw accelerometer triple. Three lanes (roll, pitch, tilt)
// each run a pipelined CORDIC magnitude followed by a pipelined CORDIC
// arctangent; a final stage merges the three angles and the zero-over-zero
// flags into one result. One request is taken every cycle while the output
// is not stalled; a stalled output holds the whole pipeline.
module accel_tilt_angles import atilt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // roll_angle, pitch_angle, vertical_tilt,
                                      // undefined_flags, zero pad
);

  logic                 adv;
  logic [PIPE_DEPTH-1:0] vld;

  logic [VW-1:0]        ax, ay, az;
  logic signed [VW-1:0] y_s, nx_s;
  logic                 zneg;

  logic signed [VW-1:0] xi, yi, zi;

  logic [VW-1:0] mag_r, mag_p, mag_t;
  side_t         sd_r, sd_p, sd_t;
  logic signed [AW-1:0] ang_r, ang_p, ang_t;
  logic                 fl_r, fl_p, fl_t;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[PIPE_DEPTH-1];

  assign xi = {s_tdata[15], s_tdata[15:0], 8'd0};
  assign yi = {s_tdata[31], s_tdata[31:16], 8'd0};
  assign zi = {s_tdata[47], s_tdata[47:32], 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax   <= xi[VW-1] ? -xi : xi;
      ay   <= yi[VW-1] ? -yi : yi;
      az   <= zi[VW-1] ? -zi : zi;
      y_s  <= yi;
      nx_s <= -xi;
      zneg <= zi[VW-1];
    end
  end

  atilt_mag u_mag_roll (
    .clk(clk), .en(adv), .a(ax), .b(az),
    .side_in('{oth: y_s, neg: 1'b0}), .mag(mag_r), .side_out(sd_r)
  );
  atilt_mag u_mag_pitch (
    .clk(clk), .en(adv), .a(ay), .b(az),
    .side_in('{oth: nx_s, neg: 1'b0}), .mag(mag_p), .side_out(sd_p)
  );
  atilt_mag u_mag_tilt (
    .clk(clk), .en(adv), .a(ax), .b(ay),
    .side_in('{oth: $signed(az), neg: zneg}), .mag(mag_t), .side_out(sd_t)
  );

  atilt_atan u_atan_roll (
    .clk(clk), .en(adv), .num(sd_r.oth), .den($signed(mag_r)), .neg(sd_r.neg),
    .ang(ang_r), .flag(fl_r)
  );
  atilt_atan u_atan_pitch (
    .clk(clk), .en(adv), .num(sd_p.oth), .den($signed(mag_p)), .neg(sd_p.neg),
    .ang(ang_p), .flag(fl_p)
  );
  atilt_atan u_atan_tilt (
    .clk(clk), .en(adv), .num($signed(mag_t)), .den(sd_t.oth), .neg(sd_t.neg),
    .ang(ang_t), .flag(fl_t)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {5'd0, fl_t, fl_p, fl_r, ang_t, ang_p, ang_r};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/atilt_mag.sv
`timescale 1ns / 1ps
`default_nettype none
module atilt_mag import atilt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] a,
  input  wire logic [VW-1:0] b,
  input  wire side_t         side_in,
  output logic      [VW-1:0] mag,
  output side_t              side_out
);

  localparam int PW = VW + GW;
  localparam logic [PW-1:0] HALF = PW'(1) << (GW - 1);

  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  side_t                sd [CORDIC_STEPS+1];
  logic [PW-1:0]        prod;

  assign xs[0] = $signed(CW'(a));
  assign ys[0] = $signed(CW'(b));
  assign sd[0] = side_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  assign prod = PW'(xs[CORDIC_STEPS][VW-1:0]) * PW'(INV_GAIN) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      mag      <= prod[PW-1:GW];
      side_out <= sd[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/atilt_atan.sv
`timescale 1ns / 1ps
`default_nettype none
module atilt_atan import atilt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [VW-1:0] num,
  input  wire logic signed [VW-1:0] den,
  input  wire logic                 neg,
  output logic signed      [AW-1:0] ang,
  output logic                      flag
);

  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs [CORDIC_STEPS+1];
  spc_t                 sp [CORDIC_STEPS+1];
  logic signed [ZW:0]   zr;
  logic signed [ZW-8:0] zsh;
  logic signed [AW-1:0] r;
  logic signed [AW-1:0] r_next;
  logic                 flag_next;

  assign xs[0] = CW'(den);
  assign ys[0] = CW'(num);
  assign zs[0] = '0;
  assign sp[0] = '{dz: den == '0, nz: num == '0, npos: !num[VW-1], neg: neg};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANGLE_TAB[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANGLE_TAB[i];
        end
        sp[i+1] <= sp[i];
      end
    end
  end

  always_comb begin
    zr  = (ZW+1)'(zs[CORDIC_STEPS]) + (ZW+1)'(128);
    zsh = zr[ZW:8];
    if (zsh > (ZW-7)'(QUARTER_TURN)) begin
      r = QUARTER_TURN;
    end else if (zsh < -(ZW-7)'(QUARTER_TURN)) begin
      r = -QUARTER_TURN;
    end else begin
      r = zsh[AW-1:0];
    end
    flag_next = 1'b0;
    if (sp[CORDIC_STEPS].dz) begin
      if (sp[CORDIC_STEPS].nz) begin
        r_next    = '0;
        flag_next = 1'b1;
      end else begin
        r_next = sp[CORDIC_STEPS].npos ? QUARTER_TURN : -QUARTER_TURN;
      end
    end else if (sp[CORDIC_STEPS].nz) begin
      r_next = '0;
    end else begin
      r_next = r;
    end
    if (sp[CORDIC_STEPS].neg) begin
      r_next = -r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang  <= r_next;
      flag <= flag_next;
    end
  end

endmodule
`default_nettype wire
